// ===== hdl/tcl_pkg.sv =====
// Package for the thermocouple linearizer: word types, ROM tables and constants.
// No dependencies; used by every module in hdl/.
`timescale 1ns / 1ps
package tcl_pkg;

   typedef struct packed {
      logic signed [15:0] measured_uv;
      logic signed [7:0]  cold_junction_c;
   } req_word_type;

   typedef struct packed {
      logic [10:0] temperature_c;
      logic        over_range;
   } rsp_word_type;

   localparam int HOT_ROM_LEN = 112;
   localparam int CJ_ROM_LEN  = 19;
   localparam int CJ_BEGIN_C  = -20;

   // Type R table, microvolts at 16 C steps from 0 C.
   function automatic logic signed [15:0] hot_rom(input logic [7:0] idx);
      logic signed [15:0] r;
      case (idx)
         8'd0: r = 16'sd0;      8'd1: r = 16'sd88;     8'd2: r = 16'sd183;
         8'd3: r = 16'sd284;    8'd4: r = 16'sd390;    8'd5: r = 16'sd501;
         8'd6: r = 16'sd618;    8'd7: r = 16'sd738;    8'd8: r = 16'sd863;
         8'd9: r = 16'sd992;    8'd10: r = 16'sd1124;  8'd11: r = 16'sd1260;
         8'd12: r = 16'sd1398;  8'd13: r = 16'sd1540;  8'd14: r = 16'sd1684;
         8'd15: r = 16'sd1831;  8'd16: r = 16'sd1980;  8'd17: r = 16'sd2131;
         8'd18: r = 16'sd2284;  8'd19: r = 16'sd2440;  8'd20: r = 16'sd2597;
         8'd21: r = 16'sd2756;  8'd22: r = 16'sd2916;  8'd23: r = 16'sd3079;
         8'd24: r = 16'sd3242;  8'd25: r = 16'sd3408;  8'd26: r = 16'sd3574;
         8'd27: r = 16'sd3742;  8'd28: r = 16'sd3912;  8'd29: r = 16'sd4083;
         8'd30: r = 16'sd4255;  8'd31: r = 16'sd4428;  8'd32: r = 16'sd4602;
         8'd33: r = 16'sd4778;  8'd34: r = 16'sd4955;  8'd35: r = 16'sd5133;
         8'd36: r = 16'sd5312;  8'd37: r = 16'sd5493;  8'd38: r = 16'sd5674;
         8'd39: r = 16'sd5857;  8'd40: r = 16'sd6041;  8'd41: r = 16'sd6227;
         8'd42: r = 16'sd6413;  8'd43: r = 16'sd6601;  8'd44: r = 16'sd6790;
         8'd45: r = 16'sd6980;  8'd46: r = 16'sd7172;  8'd47: r = 16'sd7364;
         8'd48: r = 16'sd7558;  8'd49: r = 16'sd7753;  8'd50: r = 16'sd7950;
         8'd51: r = 16'sd8147;  8'd52: r = 16'sd8346;  8'd53: r = 16'sd8546;
         8'd54: r = 16'sd8748;  8'd55: r = 16'sd8950;  8'd56: r = 16'sd9154;
         8'd57: r = 16'sd9359;  8'd58: r = 16'sd9565;  8'd59: r = 16'sd9772;
         8'd60: r = 16'sd9980;  8'd61: r = 16'sd10190; 8'd62: r = 16'sd10400;
         8'd63: r = 16'sd10612; 8'd64: r = 16'sd10825; 8'd65: r = 16'sd11039;
         8'd66: r = 16'sd11253; 8'd67: r = 16'sd11469; 8'd68: r = 16'sd11686;
         8'd69: r = 16'sd11904; 8'd70: r = 16'sd12123; 8'd71: r = 16'sd12342;
         8'd72: r = 16'sd12563; 8'd73: r = 16'sd12784; 8'd74: r = 16'sd13006;
         8'd75: r = 16'sd13228; 8'd76: r = 16'sd13451; 8'd77: r = 16'sd13674;
         8'd78: r = 16'sd13898; 8'd79: r = 16'sd14123; 8'd80: r = 16'sd14347;
         8'd81: r = 16'sd14572; 8'd82: r = 16'sd14798; 8'd83: r = 16'sd15023;
         8'd84: r = 16'sd15249; 8'd85: r = 16'sd15475; 8'd86: r = 16'sd15701;
         8'd87: r = 16'sd15927; 8'd88: r = 16'sd16153; 8'd89: r = 16'sd16379;
         8'd90: r = 16'sd16605; 8'd91: r = 16'sd16831; 8'd92: r = 16'sd17056;
         8'd93: r = 16'sd17282; 8'd94: r = 16'sd17507; 8'd95: r = 16'sd17732;
         8'd96: r = 16'sd17956; 8'd97: r = 16'sd18180; 8'd98: r = 16'sd18404;
         8'd99: r = 16'sd18627; 8'd100: r = 16'sd18849; 8'd101: r = 16'sd19071;
         8'd102: r = 16'sd19292; 8'd103: r = 16'sd19512; 8'd104: r = 16'sd19732;
         8'd105: r = 16'sd19951; 8'd106: r = 16'sd20168; 8'd107: r = 16'sd20369;
         8'd108: r = 16'sd20594; 8'd109: r = 16'sd20801; 8'd110: r = 16'sd21003;
         8'd111: r = 16'sd21201;
         default: r = 16'sd21201;
      endcase
      return r;
   endfunction

   // Cold-junction table, microvolts at 5 C steps from -20 C.
   function automatic logic signed [9:0] cj_rom(input logic [5:0] idx);
      logic signed [9:0] r;
      case (idx)
         6'd0: r = -10'sd100; 6'd1: r = -10'sd76; 6'd2: r = -10'sd52;
         6'd3: r = -10'sd26;  6'd4: r = 10'sd0;   6'd5: r = 10'sd27;
         6'd6: r = 10'sd54;   6'd7: r = 10'sd83;  6'd8: r = 10'sd111;
         6'd9: r = 10'sd141;  6'd10: r = 10'sd171; 6'd11: r = 10'sd201;
         6'd12: r = 10'sd232; 6'd13: r = 10'sd264; 6'd14: r = 10'sd296;
         6'd15: r = 10'sd329; 6'd16: r = 10'sd363; 6'd17: r = 10'sd397;
         6'd18: r = 10'sd431;
         default: r = 10'sd431;
      endcase
      return r;
   endfunction

endpackage

// ===== hdl/thermocouple_linearizer_unit.sv =====
// Top level of the type R thermocouple linearizer.
// Depends on tcl_pkg, tcl_cj_stage and tcl_hot_stage.
//
// Usage: the req_ channel takes one word per cycle (measured voltage and
// cold-junction temperature); the rsp_ channel returns one word with the
// hot-junction temperature and an over-range flag for each request, in order.
// The csr_ port writes the calibration offset register; write it only
// while the pipeline is empty.
// Pipeline: 3 cold-junction stages, 1 + ceil(log2(entries - 1)) search stages
// and 2 interpolation stages.
// Throughput: one word per cycle; the search steps, one per pipeline stage,
// set the depth.
// Reset clears all valid bits and sets the offset to zero.
// When the receiver stalls, the whole pipeline holds; req_ready drops
// until the output word is taken, and nothing is lost or repeated.
`timescale 1ns / 1ps
module thermocouple_linearizer_unit #(
   parameter int HOT_ENTRIES = 112,
   parameter int HOT_STEP_C  = 16,
   parameter int CJ_ENTRIES  = 19,
   parameter int CJ_STEP_C   = 5
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  tcl_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output tcl_pkg::rsp_word_type rsp_word,
   input  logic                  csr_we,
   input  logic signed [12:0]    csr_wdata
);
   localparam int HOT_N = (HOT_ENTRIES < tcl_pkg::HOT_ROM_LEN) ? HOT_ENTRIES
                                                              : tcl_pkg::HOT_ROM_LEN;

   logic               adv;
   logic               mid_valid;
   logic signed [15:0] mid_sum;
   logic signed [12:0] cal_ff;

   // The pipeline moves whenever the output slot is free or being drained.
   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   // Calibration offset register.
   always_ff @(posedge clock) begin
      if (reset) begin
         cal_ff <= 13'sd0;
      end else if (csr_we) begin
         cal_ff <= csr_wdata;
      end
   end

   tcl_cj_stage #(.CJ_ENTRIES(CJ_ENTRIES), .CJ_STEP_C(CJ_STEP_C)) u_cj (
      .clock(clock), .reset(reset), .adv(adv),
      .in_valid(req_valid), .in_word(req_word), .cal_offset(cal_ff),
      .out_valid(mid_valid), .out_sum(mid_sum)
   );

   tcl_hot_stage #(.HOT_ENTRIES(HOT_ENTRIES), .HOT_STEP_C(HOT_STEP_C)) u_hot (
      .clock(clock), .reset(reset), .adv(adv),
      .in_valid(mid_valid), .in_sum(mid_sum),
      .out_valid(rsp_valid), .out_word(rsp_word)
   );

   // Checks on the stall behavior and the result range.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("result word changed during stall");
   a_noacc: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input accepted during stall");
   a_over: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.over_range |->
      rsp_word.temperature_c == 11'(HOT_STEP_C * (HOT_N - 1)))
      else $error("over-range without full-scale temperature");
endmodule

// ===== hdl/tcl_cj_stage.sv =====
// Cold-junction compensation stages: clamp, table lookup, interpolate, add, saturate.
// Depends on tcl_pkg.
`timescale 1ns / 1ps
module tcl_cj_stage #(
   parameter int CJ_ENTRIES = 19,
   parameter int CJ_STEP_C  = 5
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     adv,
   input  logic                     in_valid,
   input  tcl_pkg::req_word_type    in_word,
   input  logic signed [12:0]       cal_offset,
   output logic                     out_valid,
   output logic signed [15:0]       out_sum
);
   localparam int CJ_N   = (CJ_ENTRIES < tcl_pkg::CJ_ROM_LEN) ? CJ_ENTRIES : tcl_pkg::CJ_ROM_LEN;
   localparam int CJ_END = tcl_pkg::CJ_BEGIN_C + CJ_STEP_C * (CJ_N - 1);
   // Reciprocal of the step in 20 fractional bits; exact for the small dividends used here.
   localparam int CJ_RECIP = (2 ** 20 + CJ_STEP_C - 1) / CJ_STEP_C;

   // Stage A: clamp and split into index and remainder.
   logic               a_valid_ff;
   logic signed [15:0] a_meas_ff;
   logic [5:0]         a_idx_ff, a_idx_in;
   logic [4:0]         a_rem_ff, a_rem_in;
   logic signed [12:0] a_cal_ff;
   logic [9:0]         off;
   logic [30:0]        off_scaled;

   always_comb begin
      off = 10'(signed'(10'(in_word.cold_junction_c)) - 10'(tcl_pkg::CJ_BEGIN_C));
      off_scaled = 31'(off) * 31'(CJ_RECIP);
      if ($signed(in_word.cold_junction_c) <= tcl_pkg::CJ_BEGIN_C) begin
         a_idx_in = 6'd0;
         a_rem_in = 5'd0;
      end else if ($signed(in_word.cold_junction_c) >= CJ_END) begin
         a_idx_in = 6'(CJ_N - 2);
         a_rem_in = 5'(CJ_STEP_C);
      end else begin
         a_idx_in = off_scaled[25:20];
         a_rem_in = 5'(off - 10'(a_idx_in) * 10'(CJ_STEP_C));
         if (a_idx_in > 6'(CJ_N - 2)) begin
            a_idx_in = 6'(CJ_N - 2);
            a_rem_in = 5'(off - 10'((CJ_N - 2) * CJ_STEP_C));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= in_valid;
      end
      if (adv) begin
         a_meas_ff <= in_word.measured_uv;
         a_idx_ff  <= a_idx_in;
         a_rem_ff  <= a_rem_in;
         a_cal_ff  <= cal_offset;
      end
   end

   // Stage B: table reads and the interpolation product.
   logic               b_valid_ff;
   logic signed [15:0] b_meas_ff;
   logic signed [9:0]  b_base_ff;
   logic signed [15:0] b_prod_ff;
   logic signed [12:0] b_cal_ff;
   logic signed [9:0]  lo, hi;

   assign lo = tcl_pkg::cj_rom(a_idx_ff);
   assign hi = tcl_pkg::cj_rom(a_idx_ff + 6'd1);

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (adv) begin
         b_valid_ff <= a_valid_ff;
      end
      if (adv) begin
         b_meas_ff <= a_meas_ff;
         b_base_ff <= lo;
         b_prod_ff <= 16'(signed'({1'b0, a_rem_ff}) * (16'(hi) - 16'(lo)));
         b_cal_ff  <= a_cal_ff;
      end
   end

   // Stage C: divide by the step, add everything and saturate.
   logic signed [18:0] sum;
   logic signed [15:0] sat;
   logic [36:0]        frac_scaled;
   logic               c_valid_ff;
   logic signed [15:0] c_sum_ff;

   always_comb begin
      // The product is never negative, so the reciprocal multiply truncates like a divide.
      frac_scaled = 37'(b_prod_ff[15:0]) * 37'(CJ_RECIP);
      sum = 19'(b_meas_ff) + 19'(b_base_ff) + signed'({3'b000, frac_scaled[35:20]})
            + 19'(b_cal_ff);
      if (sum > 19'sd32767) sat = 16'sh7fff;
      else if (sum < -19'sd32768) sat = 16'sh8000;
      else sat = sum[15:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (adv) begin
         c_valid_ff <= b_valid_ff;
      end
      if (adv) begin
         c_sum_ff <= sat;
      end
   end

   assign out_valid = c_valid_ff;
   assign out_sum   = c_sum_ff;
endmodule

// ===== hdl/tcl_hot_stage.sv =====
// Hot-junction conversion: one binary-search step per stage, then interpolation.
// Depends on tcl_pkg.
`timescale 1ns / 1ps
module tcl_hot_stage #(
   parameter int HOT_ENTRIES = 112,
   parameter int HOT_STEP_C  = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic                  in_valid,
   input  logic signed [15:0]    in_sum,
   output logic                  out_valid,
   output tcl_pkg::rsp_word_type out_word
);
   localparam int HOT_N  = (HOT_ENTRIES < tcl_pkg::HOT_ROM_LEN) ? HOT_ENTRIES
                                                                : tcl_pkg::HOT_ROM_LEN;
   localparam int STEPS  = (HOT_N > 2) ? $clog2(HOT_N - 1) : 1;
   localparam int MAXT   = HOT_STEP_C * (HOT_N - 1);

   // Per-stage search state: bounds, exact-hit flag and end-clamp code.
   typedef struct packed {
      logic               valid;
      logic signed [15:0] v;
      logic [7:0]         a;
      logic [7:0]         b;
      logic               hit;
      logic [7:0]         hit_idx;
      logic               low;
      logic               high;
      logic               over;
   } srch_type;

   srch_type st_ff [STEPS+1];
   srch_type st_in [STEPS+1];

   // Entry: check both ends of the table.
   always_comb begin
      st_in[0].valid   = in_valid;
      st_in[0].v       = in_sum;
      st_in[0].a       = 8'd0;
      st_in[0].b       = 8'(HOT_N - 1);
      st_in[0].hit     = 1'b0;
      st_in[0].hit_idx = 8'd0;
      st_in[0].low     = in_sum <= tcl_pkg::hot_rom(8'd0);
      st_in[0].high    = in_sum >= tcl_pkg::hot_rom(8'(HOT_N - 1));
      st_in[0].over    = in_sum > tcl_pkg::hot_rom(8'(HOT_N - 1));
   end

   // Search steps, each halving the bracket.
   for (genvar g = 1; g <= STEPS; g++) begin : g_step
      logic [7:0]         mid;
      logic signed [15:0] rv;
      always_comb begin
         mid = 8'((9'(st_ff[g-1].a) + 9'(st_ff[g-1].b)) >> 1);
         rv  = tcl_pkg::hot_rom(mid);
         st_in[g] = st_ff[g-1];
         if (!st_ff[g-1].hit && (st_ff[g-1].b - st_ff[g-1].a > 8'd1)) begin
            if (st_ff[g-1].v == rv) begin
               st_in[g].hit     = 1'b1;
               st_in[g].hit_idx = mid;
            end else if (st_ff[g-1].v < rv) begin
               st_in[g].b = mid;
            end else begin
               st_in[g].a = mid;
            end
         end
      end
   end

   for (genvar g = 0; g <= STEPS; g++) begin : g_reg
      always_ff @(posedge clock) begin
         if (reset) begin
            st_ff[g].valid <= 1'b0;
         end else if (adv) begin
            st_ff[g].valid <= st_in[g].valid;
         end
         if (adv) begin
            st_ff[g].v       <= st_in[g].v;
            st_ff[g].a       <= st_in[g].a;
            st_ff[g].b       <= st_in[g].b;
            st_ff[g].hit     <= st_in[g].hit;
            st_ff[g].hit_idx <= st_in[g].hit_idx;
            st_ff[g].low     <= st_in[g].low;
            st_ff[g].high    <= st_in[g].high;
            st_ff[g].over    <= st_in[g].over;
         end
      end
   end

   // Interpolation product stage.
   srch_type           f;
   logic signed [15:0] ra, rb;
   logic               p_valid_ff;
   logic [22:0]        p_num_ff;
   logic [15:0]        p_den_ff;
   logic [10:0]        p_base_ff;
   logic               p_fixed_ff, p_over_ff;
   logic [10:0]        p_fixed_t_ff;
   logic [10:0]        fixed_t;
   logic               fixed;

   assign f  = st_ff[STEPS];
   assign ra = tcl_pkg::hot_rom(f.a);
   assign rb = tcl_pkg::hot_rom(f.b);

   always_comb begin
      fixed   = 1'b1;
      fixed_t = 11'd0;
      if (f.low) fixed_t = 11'd0;
      else if (f.high) fixed_t = 11'(MAXT);
      else if (f.hit) fixed_t = 11'(HOT_STEP_C * f.hit_idx);
      else if (rb <= ra) fixed_t = 11'(HOT_STEP_C * f.a);
      else fixed = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else if (adv) begin
         p_valid_ff <= f.valid;
      end
      if (adv) begin
         p_num_ff     <= 23'(HOT_STEP_C) * 23'(16'(f.v - ra));
         p_den_ff     <= 16'(rb - ra);
         p_base_ff    <= 11'(HOT_STEP_C * f.a);
         p_fixed_ff   <= fixed;
         p_fixed_t_ff <= fixed_t;
         p_over_ff    <= f.over;
      end
   end

   // Quotient: the fraction stays below one step, so a few restoring steps suffice.
   localparam int QB = $clog2(HOT_STEP_C + 1);
   logic [QB-1:0] q;
   logic [22:0]   rem;
   always_comb begin
      rem = p_num_ff;
      q   = '0;
      for (int i = QB - 1; i >= 0; i--) begin
         if (rem >= (23'(p_den_ff) << i)) begin
            rem  = rem - (23'(p_den_ff) << i);
            q[i] = 1'b1;
         end
      end
   end

   logic                  o_valid_ff;
   tcl_pkg::rsp_word_type o_word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
      end else if (adv) begin
         o_valid_ff <= p_valid_ff;
      end
      if (adv) begin
         o_word_ff.temperature_c <= p_fixed_ff ? p_fixed_t_ff : p_base_ff + 11'(q);
         o_word_ff.over_range    <= p_over_ff;
      end
   end

   assign out_valid = o_valid_ff;
   assign out_word  = o_word_ff;
endmodule

// ===== bench/tb_top.sv =====
// Testbench for thermocouple_linearizer_unit: directed and random words with a
// software temperature predictor. Depends on tcl_pkg and the unit's RTL.
`timescale 1ns / 1ps
module tb_top;

   localparam int CLK_HALF = 6;
   localparam int LATENCY  = 13;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   tcl_pkg::req_word_type req_word = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   tcl_pkg::rsp_word_type rsp_word;
   logic                  csr_we = 1'b0;
   logic signed [12:0]    csr_wdata = '0;

   // Predictor copy of the calibration offset and expected result queue.
   int                    offset_uv = 0;
   tcl_pkg::rsp_word_type expected_temps[$];
   int                    error_count = 0;
   int                    word_count = 0;
   int                    rsp_count = 0;
   int                    overrange_count = 0;
   bit                    long_hold = 1'b0;

   thermocouple_linearizer_unit u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_word(rsp_word),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #CLK_HALF clock = ~clock;
   end

   // Private tables for the predictor, in microvolts.
   int hot_uv[112] = '{
          0,    88,   183,   284,   390,   501,   618,   738,
        863,   992,  1124,  1260,  1398,  1540,  1684,  1831,
       1980,  2131,  2284,  2440,  2597,  2756,  2916,  3079,
       3242,  3408,  3574,  3742,  3912,  4083,  4255,  4428,
       4602,  4778,  4955,  5133,  5312,  5493,  5674,  5857,
       6041,  6227,  6413,  6601,  6790,  6980,  7172,  7364,
       7558,  7753,  7950,  8147,  8346,  8546,  8748,  8950,
       9154,  9359,  9565,  9772,  9980, 10190, 10400, 10612,
      10825, 11039, 11253, 11469, 11686, 11904, 12123, 12342,
      12563, 12784, 13006, 13228, 13451, 13674, 13898, 14123,
      14347, 14572, 14798, 15023, 15249, 15475, 15701, 15927,
      16153, 16379, 16605, 16831, 17056, 17282, 17507, 17732,
      17956, 18180, 18404, 18627, 18849, 19071, 19292, 19512,
      19732, 19951, 20168, 20369, 20594, 20801, 21003, 21201};
   int cj_uv[19] = '{-100, -76, -52, -26, 0, 27, 54, 83, 111, 141, 171, 201,
                     232, 264, 296, 329, 363, 397, 431};

   // Cold-junction compensation voltage, clamped to the -20..70 C span.
   function automatic int cold_junction_uv(int t);
      int off;
      int idx;
      int rem;
      if (t <= -20) return cj_uv[0];
      if (t >= 70) return cj_uv[18];
      off = t + 20;
      idx = off / 5;
      rem = off % 5;
      return cj_uv[idx] + (rem * (cj_uv[idx + 1] - cj_uv[idx])) / 5;
   endfunction

   // Hot-junction temperature from a compensated voltage via search and interpolation.
   function automatic int hot_temp_c(int v);
      int lo;
      int hi;
      int mid;
      lo = 0;
      hi = 111;
      if (v <= hot_uv[0]) return 0;
      if (v >= hot_uv[111]) return 16 * 111;
      while (hi - lo > 1) begin
         mid = (lo + hi) / 2;
         if (v == hot_uv[mid]) return 16 * mid;
         if (v < hot_uv[mid]) hi = mid; else lo = mid;
      end
      return 16 * lo + (16 * (v - hot_uv[lo])) / (hot_uv[hi] - hot_uv[lo]);
   endfunction

   function automatic tcl_pkg::rsp_word_type linearize(tcl_pkg::req_word_type w);
      tcl_pkg::rsp_word_type r;
      int sum;
      sum = int'(w.measured_uv) + cold_junction_uv(int'(w.cold_junction_c)) + offset_uv;
      if (sum > 32767) sum = 32767;
      if (sum < -32768) sum = -32768;
      r.temperature_c = 11'(hot_temp_c(sum));
      r.over_range = (sum > hot_uv[111]);
      return r;
   endfunction

   // Random gap: mostly none or short, occasionally long.
   function automatic int gap_cycles();
      int p;
      p = $urandom_range(0, 99);
      if (p < 45) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Send one word; the expectation is queued when the word is accepted.
   // Valid stays high after acceptance and drops only when a gap follows or the test drains.
   task automatic send_word(input logic signed [15:0] uv, input logic signed [7:0] cj,
                            input bit gaps);
      tcl_pkg::req_word_type w;
      int n;
      w.measured_uv = uv;
      w.cold_junction_c = cj;
      n = gaps ? gap_cycles() : 0;
      if (n > 0) req_valid <= 1'b0;
      repeat (n) @(posedge clock);
      req_valid <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_temps.push_back(linearize(w));
      word_count++;
   endtask

   task automatic drain_and_idle();
      req_valid <= 1'b0;
      while (expected_temps.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_offset(input int value);
      csr_we <= 1'b1;
      csr_wdata <= 13'(value);
      @(posedge clock);
      csr_we <= 1'b0;
      offset_uv = value;
      @(posedge clock);
   endtask

   // Receiver stall pattern, with one long hold requested by the pressure test.
   initial begin
      int n;
      @(negedge reset);
      forever begin
         if (long_hold) begin
            rsp_ready <= 1'b0;
            repeat (60) @(posedge clock);
            long_hold = 1'b0;
         end
         n = gap_cycles();
         if (n == 0) begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end else begin
            rsp_ready <= 1'b0;
            repeat (n) @(posedge clock);
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
   end

   // Result checker against the oldest expected word.
   always @(posedge clock) begin
      tcl_pkg::rsp_word_type exp_w;
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_count++;
         if (expected_temps.size() == 0) begin
            $error("unexpected output word %h", rsp_word);
            error_count++;
         end else begin
            exp_w = expected_temps.pop_front();
            if (exp_w.over_range) overrange_count++;
            if (rsp_word.temperature_c !== exp_w.temperature_c) begin
               $error("temperature_c expected %0d actual %0d",
                      exp_w.temperature_c, rsp_word.temperature_c);
               error_count++;
            end
            if (rsp_word.over_range !== exp_w.over_range) begin
               $error("over_range expected %0d actual %0d",
                      exp_w.over_range, rsp_word.over_range);
               error_count++;
            end
         end
      end
   end

   // Field extremes, cold-junction clamps, table ends, exact grid points, saturation.
   task automatic test_directed();
      send_word(16'sh8000, -8'sd128, 0);
      send_word(16'sh7FFF, 8'sd127, 0);
      send_word(16'sd0, -8'sd20, 0);
      send_word(16'sd0, 8'sd70, 0);
      send_word(16'sd100, -8'sd21, 0);
      send_word(16'sd500, 8'sd71, 0);
      send_word(16'sd0, 8'sd0, 0);
      send_word(16'sd88, 8'sd0, 0);
      send_word(16'sd10825, 8'sd0, 0);
      send_word(16'sd21201, 8'sd0, 0);
      send_word(16'sd21202, 8'sd0, 0);
      send_word(16'sd21200, 8'sd0, 0);
      send_word(16'sd5000, 8'sd23, 0);
      send_word(-16'sd1, 8'sd0, 0);
      send_word(16'sd32700, 8'sd70, 0);
      send_word(-16'sd32700, -8'sd20, 0);
      send_word(16'sd12000, -8'sd7, 0);
      send_word(16'sh5555, 8'sh55, 0);
      send_word(16'shAAAA, 8'shAA, 0);
      drain_and_idle();
   endtask

   // Random words, mostly inside the useful span, some across the full range.
   task automatic test_random(input int count);
      logic signed [15:0] uv;
      logic signed [7:0]  cj;
      repeat (count) begin
         if ($urandom_range(0, 3) == 0) uv = 16'($urandom);
         else uv = 16'($urandom_range(0, 21700)) - 16'sd200;
         if ($urandom_range(0, 3) == 0) cj = 8'($urandom);
         else cj = 8'($urandom_range(0, 95)) - 8'sd22;
         send_word(uv, cj, 1);
      end
      drain_and_idle();
   endtask

   // Long receiver hold while words keep coming, so the input stalls.
   task automatic test_backpressure();
      long_hold = 1'b1;
      repeat (40) send_word(16'($urandom_range(0, 21201)), 8'($urandom_range(0, 60)), 0);
      drain_and_idle();
   endtask

   // Offset sweeps including both extremes.
   task automatic test_offsets();
      write_offset(4095);
      test_random(80);
      send_word(16'sd21201, 8'sd70, 0);
      drain_and_idle();
      write_offset(-4096);
      test_random(80);
      send_word(-16'sd32768, -8'sd20, 0);
      drain_and_idle();
      write_offset($urandom_range(0, 8191) - 4096);
      test_random(80);
      write_offset(0);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_backpressure();
      test_random(500);
      test_offsets();
      $display("Sent %0d words, checked %0d results, %0d over range.",
               word_count, rsp_count, overrange_count);
      $display("Covered offset extremes, saturation, clamps and a long output stall.");
      if (error_count == 0 && expected_temps.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Watchdog.
   initial begin
      #5ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
